@@ rtl/core/pli_pkg.sv @@
// Shared types and constants for the piecewise linear interpolator.
// Holds table sizing, the controller state encoding and the command and status structs.
// Used by pli_ctrl, pli_datapath and piecewise_linear_interpolator.
package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int CFG_W       = 7;
    localparam int Q_W         = FRAC_W + 1;
    localparam int CNT_W       = $clog2(Q_W);
    localparam int ENTRY_W     = 2 * DATA_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_LAST  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_ADD   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic write_entry;
        logic load_query;
        logic chk_first;
        logic chk_last;
        logic scan;
        logic div_step;
        logic mul;
        logic fin;
    } t_ctrl;

    typedef struct packed {
        logic le_first;
        logic ge_last;
        logic scan_hit;
        logic div_last;
    } t_stat;

endpackage

@@ rtl/core/pli_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Has no dependencies.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pli_ctrl.sv @@
// Controller state machine for the piecewise linear interpolator.
// Sequences clamping checks, the segment scan, the divide and the final multiply-add.
// Depends on pli_pkg.
module pli_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_cmd,
    input  pli_pkg::t_stat i_stat,
    output pli_pkg::t_ctrl o_ctrl,
    output logic           busy,
    output logic           o_result_strobe
);

    pli_pkg::t_state r_state, n_state;
    logic            r_strobe, n_strobe;
    logic            accept;

    assign accept = start && (r_state == pli_pkg::S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        unique case (r_state)
            pli_pkg::S_IDLE: begin
                if (accept && (i_cmd == pli_pkg::CMD_QUERY)) begin
                    n_state = pli_pkg::S_FIRST;
                end
            end
            pli_pkg::S_FIRST: begin
                if (i_stat.le_first) begin
                    n_state  = pli_pkg::S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_state = pli_pkg::S_LAST;
                end
            end
            pli_pkg::S_LAST: begin
                if (i_stat.ge_last) begin
                    n_state  = pli_pkg::S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_state = pli_pkg::S_SCAN;
                end
            end
            pli_pkg::S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = pli_pkg::S_DIV;
                end
            end
            pli_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = pli_pkg::S_MUL;
                end
            end
            pli_pkg::S_MUL: begin
                n_state = pli_pkg::S_ADD;
            end
            pli_pkg::S_ADD: begin
                n_state  = pli_pkg::S_IDLE;
                n_strobe = 1'b1;
            end
            default: begin
                n_state = pli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pli_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_comb begin
        o_ctrl             = '0;
        o_ctrl.write_entry = accept && (i_cmd == pli_pkg::CMD_WRITE);
        o_ctrl.load_query  = accept && (i_cmd == pli_pkg::CMD_QUERY);
        o_ctrl.chk_first   = (r_state == pli_pkg::S_FIRST);
        o_ctrl.chk_last    = (r_state == pli_pkg::S_LAST);
        o_ctrl.scan        = (r_state == pli_pkg::S_SCAN);
        o_ctrl.div_step    = (r_state == pli_pkg::S_DIV);
        o_ctrl.mul         = (r_state == pli_pkg::S_MUL);
        o_ctrl.fin         = (r_state == pli_pkg::S_ADD);
    end

    assign busy            = (r_state != pli_pkg::S_IDLE);
    assign o_result_strobe = r_strobe;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == pli_pkg::S_IDLE))
        else $error("result strobe outside idle");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == pli_pkg::CMD_QUERY)) |=> (r_state == pli_pkg::S_FIRST))
        else $error("accepted query did not start the clamp check");

    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pli_pkg::S_DIV) && i_stat.div_last) |=> (r_state == pli_pkg::S_MUL))
        else $error("divide did not hand over to the multiply");
`endif

endmodule

@@ rtl/core/pli_datapath.sv @@
// Datapath for the piecewise linear interpolator: breakpoint RAM, scan registers,
// restoring fraction divider, multiplier and final adder.
// Depends on pli_pkg and pli_ram.
module pli_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pli_pkg::t_ctrl              i_ctrl,
    output pli_pkg::t_stat              o_stat,
    input  logic                        i_cfg_we,
    input  logic [pli_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [5:0]                  i_entry_index,
    input  logic signed [31:0]          i_entry_position,
    input  logic signed [31:0]          i_entry_value,
    input  logic signed [31:0]          i_query_x,
    output logic signed [31:0]          o_result_y
);

    localparam int DW = pli_pkg::DATA_W;
    localparam int FW = pli_pkg::FRAC_W;
    localparam int QW = pli_pkg::Q_W;
    localparam int PW = QW + 1 + DW + 1;

    pli_pkg::t_idx                   r_last_idx;
    pli_pkg::t_idx                   r_scan_addr;
    pli_pkg::t_idx                   raddr;
    logic                            ram_we;
    logic [pli_pkg::ENTRY_W-1:0]     rdata;
    logic signed [DW-1:0]            rd_pos;
    logic signed [DW-1:0]            rd_val;
    logic signed [DW-1:0]            r_x;
    logic signed [DW-1:0]            r_x0;
    logic signed [DW-1:0]            r_y0;
    logic signed [DW-1:0]            r_result;
    logic [DW+1:0]                   r_rem;
    logic [DW:0]                     r_div;
    logic signed [DW:0]              r_dy;
    logic [QW-1:0]                   r_q;
    logic [pli_pkg::CNT_W-1:0]       r_cnt;
    logic signed [PW-1:0]            r_prod;
    logic [DW+1:0]                   dx_ext;
    logic [DW:0]                     dd_ext;
    logic                            q_bit;
    logic [DW+1:0]                   rem_sub;

    assign ram_we = i_ctrl.write_entry && (32'(i_entry_index) < pli_pkg::TABLE_DEPTH);

    always_comb begin
        priority if (i_ctrl.chk_first) begin
            raddr = r_last_idx;
        end else if (i_ctrl.chk_last) begin
            raddr = pli_pkg::IDX_W'(1);
        end else if (i_ctrl.scan) begin
            raddr = pli_pkg::IDX_W'(r_scan_addr + 1'b1);
        end else begin
            raddr = '0;
        end
    end

    pli_ram #(
        .WIDTH (pli_pkg::ENTRY_W),
        .DEPTH (pli_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pli_pkg::t_idx'(i_entry_index)),
        .i_wdata ({i_entry_position, i_entry_value}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_pos = rdata[pli_pkg::ENTRY_W-1:DW];
    assign rd_val = rdata[DW-1:0];

    assign dx_ext  = {{2{r_x[DW-1]}}, r_x} - {{2{r_x0[DW-1]}}, r_x0};
    assign dd_ext  = {rd_pos[DW-1], rd_pos} - {r_x0[DW-1], r_x0};
    assign q_bit   = (r_rem >= {1'b0, r_div});
    assign rem_sub = q_bit ? (r_rem - {1'b0, r_div}) : r_rem;

    always_comb begin
        o_stat          = '0;
        o_stat.le_first = (r_x <= rd_pos);
        o_stat.ge_last  = (r_x >= rd_pos);
        o_stat.scan_hit = (rd_pos >= r_x);
        o_stat.div_last = (r_cnt == pli_pkg::CNT_W'(FW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= '0;
        end else if (i_cfg_we) begin
            priority if (i_cfg_wdata == '0) begin
                r_last_idx <= '0;
            end else if (32'(i_cfg_wdata) > pli_pkg::TABLE_DEPTH) begin
                r_last_idx <= pli_pkg::IDX_W'(pli_pkg::TABLE_DEPTH - 1);
            end else begin
                r_last_idx <= pli_pkg::IDX_W'(i_cfg_wdata - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_query) begin
            r_x <= i_query_x;
        end
        if (i_ctrl.chk_first) begin
            r_x0     <= rd_pos;
            r_y0     <= rd_val;
            r_result <= rd_val;
        end
        if (i_ctrl.chk_last) begin
            r_result    <= rd_val;
            r_scan_addr <= pli_pkg::IDX_W'(1);
        end
        if (i_ctrl.scan) begin
            if (o_stat.scan_hit) begin
                r_rem <= dx_ext;
                r_div <= dd_ext;
                r_dy  <= {rd_val[DW-1], rd_val} - {r_y0[DW-1], r_y0};
                r_cnt <= '0;
            end else begin
                r_x0        <= rd_pos;
                r_y0        <= rd_val;
                r_scan_addr <= pli_pkg::IDX_W'(r_scan_addr + 1'b1);
            end
        end
        if (i_ctrl.div_step) begin
            r_q   <= {r_q[QW-2:0], q_bit};
            r_rem <= {rem_sub[DW:0], 1'b0};
            r_cnt <= pli_pkg::CNT_W'(r_cnt + 1'b1);
        end
        if (i_ctrl.mul) begin
            r_prod <= $signed({1'b0, r_q}) * r_dy;
        end
        if (i_ctrl.fin) begin
            r_result <= r_y0 + r_prod[FW+DW-1:FW];
        end
    end

    assign o_result_y = r_result;

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan |-> (r_scan_addr <= r_last_idx))
        else $error("segment scan ran past the last used entry");

    a_fraction_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.mul |-> (r_q <= QW'(1 << FW)))
        else $error("interpolation fraction above one");
`endif

endmodule

@@ rtl/core/piecewise_linear_interpolator.sv @@
// Top level of the piecewise linear interpolator over a written breakpoint table.
// Instantiates pli_ctrl and pli_datapath; depends on pli_pkg.
//
// Channel   Direction  Handshake                         Payload
// command   in         start high while busy low         i_cmd, i_entry_index,
//                                                        i_entry_position, i_entry_value,
//                                                        i_query_x
// result    out        o_result_strobe, one cycle        o_result_y
// config    in         i_cfg_we                          i_cfg_wdata (points in use)
//
// A write word gives no result. A query word ends after the S_FIRST check when it clamps
// at the first entry, after the S_LAST check when it clamps at the last, and otherwise runs
// the linear scan, which reads entries from index 1 up to points in use - 1 through the
// single RAM read port, then the one-bit-per-cycle fraction divide, the multiply and the add.
// Reset is synchronous, active low, and leaves points in use at one; the table is not cleared.
// The receiver cannot stall; the strobe is asserted for one cycle per query word.
module piecewise_linear_interpolator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cmd,
    input  logic [5:0]                i_entry_index,
    input  logic signed [31:0]        i_entry_position,
    input  logic signed [31:0]        i_entry_value,
    input  logic signed [31:0]        i_query_x,
    input  logic                      i_cfg_we,
    input  logic [6:0]                i_cfg_wdata,
    output logic                      o_result_strobe,
    output logic signed [31:0]        o_result_y
);

    pli_pkg::t_ctrl ctrl;
    pli_pkg::t_stat stat;

    pli_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_cmd           (i_cmd),
        .i_stat          (stat),
        .o_ctrl          (ctrl),
        .busy            (busy),
        .o_result_strobe (o_result_strobe)
    );

    pli_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_entry_index    (i_entry_index),
        .i_entry_position (i_entry_position),
        .i_entry_value    (i_entry_value),
        .i_query_x        (i_query_x),
        .o_result_y       (o_result_y)
    );

endmodule

@@ bench/testbench.sv @@
// Testbench for piecewise_linear_interpolator: writes breakpoint tables, sets the points
// in use and checks every interpolated word against a predictor built on its own table copy.
// Depends on pli_pkg and the piecewise_linear_interpolator RTL only.
module testbench;

    typedef enum logic [1:0] {ACT_WORD, ACT_SETUP, ACT_RATE, ACT_FLUSH} t_act;

    typedef struct packed {
        t_act                              act;
        logic                              cmd;
        logic [pli_pkg::IDX_W-1:0]         idx;
        logic signed [pli_pkg::DATA_W-1:0] pos;
        logic signed [pli_pkg::DATA_W-1:0] val;
        logic signed [pli_pkg::DATA_W-1:0] qx;
        logic [pli_pkg::CFG_W-1:0]         points;
        logic [6:0]                        idle_pct;
    } t_work;

    localparam int     WORD_TARGET  = 1800;
    localparam int     QUIET_CYCLES = 8;
    localparam int     DRAIN_CYCLES = 200;
    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;
    localparam logic signed [pli_pkg::DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [pli_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              i_cmd = pli_pkg::CMD_WRITE;
    logic [pli_pkg::IDX_W-1:0]         i_entry_index = '0;
    logic signed [pli_pkg::DATA_W-1:0] i_entry_position = '0;
    logic signed [pli_pkg::DATA_W-1:0] i_entry_value = '0;
    logic signed [pli_pkg::DATA_W-1:0] i_query_x = '0;
    logic                              i_cfg_we = 1'b0;
    logic [pli_pkg::CFG_W-1:0]         i_cfg_wdata = '0;
    logic                              o_result_strobe;
    logic signed [pli_pkg::DATA_W-1:0] o_result_y;

    piecewise_linear_interpolator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_entry_index    (i_entry_index),
        .i_entry_position (i_entry_position),
        .i_entry_value    (i_entry_value),
        .i_query_x        (i_query_x),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_strobe  (o_result_strobe),
        .o_result_y       (o_result_y)
    );

    always #2 i_clk = ~i_clk;

    t_work                             pending_words[$];
    logic signed [pli_pkg::DATA_W-1:0] expected_y[$];
    logic signed [pli_pkg::DATA_W-1:0] model_pos[pli_pkg::TABLE_DEPTH];
    logic signed [pli_pkg::DATA_W-1:0] model_val[pli_pkg::TABLE_DEPTH];
    logic [pli_pkg::CFG_W-1:0]         model_points = 7'd1;
    logic signed [pli_pkg::DATA_W-1:0] plan_pos[pli_pkg::TABLE_DEPTH];
    int                                planned_words = 0;
    int                                mismatch_count = 0;
    int                                idle_pct = 0;
    int                                quiet_cycles = 0;
    logic                              word_taken = 1'b0;
    logic                              stim_done = 1'b0;
    logic                              start_nx;
    logic                              cfg_we_nx;
    t_work                             head;

    function automatic int used_points(logic [pli_pkg::CFG_W-1:0] p);
        if (p == '0) return 1;
        if (int'(p) > pli_pkg::TABLE_DEPTH) return pli_pkg::TABLE_DEPTH;
        return int'(p);
    endfunction

    function automatic logic signed [pli_pkg::DATA_W-1:0] interpolate_y(
            logic signed [pli_pkg::DATA_W-1:0] qx);
        int     n;
        int     seg;
        longint x;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        longint frac;
        n = used_points(model_points);
        x = longint'(qx);
        if (x <= longint'(model_pos[0])) return model_val[0];
        if (x >= longint'(model_pos[n-1])) return model_val[n-1];
        seg = 0;
        while (seg < n - 1 && longint'(model_pos[seg+1]) < x) seg++;
        x0 = longint'(model_pos[seg]);
        x1 = longint'(model_pos[seg+1]);
        y0 = longint'(model_val[seg]);
        y1 = longint'(model_val[seg+1]);
        // The segment always satisfies x0 < x <= x1, so the fraction is nonnegative.
        frac = ((x - x0) <<< pli_pkg::FRAC_W) / (x1 - x0);
        return pli_pkg::DATA_W'(y0 + ((frac * (y1 - y0)) >>> pli_pkg::FRAC_W));
    endfunction

    task automatic report_mismatch(string what, logic [pli_pkg::DATA_W-1:0] got,
                                   logic [pli_pkg::DATA_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic add_write(int idx, logic signed [pli_pkg::DATA_W-1:0] pos,
                             logic signed [pli_pkg::DATA_W-1:0] val);
        t_work w;
        w = '0;
        w.act = ACT_WORD;
        w.cmd = pli_pkg::CMD_WRITE;
        w.idx = pli_pkg::IDX_W'(idx);
        w.pos = pos;
        w.val = val;
        w.qx = $urandom;
        pending_words.push_back(w);
        plan_pos[idx] = pos;
        planned_words++;
    endtask

    task automatic add_query(logic signed [pli_pkg::DATA_W-1:0] qx);
        t_work w;
        w = '0;
        w.act = ACT_WORD;
        w.cmd = pli_pkg::CMD_QUERY;
        w.idx = pli_pkg::IDX_W'($urandom);
        w.pos = $urandom;
        w.val = $urandom;
        w.qx = qx;
        pending_words.push_back(w);
        planned_words++;
    endtask

    task automatic add_control(t_act act, int value);
        t_work w;
        w = '0;
        w.act = act;
        w.points = pli_pkg::CFG_W'(value);
        w.idle_pct = 7'(value);
        pending_words.push_back(w);
    endtask

    function automatic logic signed [pli_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            default: return int'($urandom) >>> 8;
        endcase
    endfunction

    function automatic logic signed [pli_pkg::DATA_W-1:0] pick_query(int n);
        longint lo;
        longint hi;
        int     k;
        lo = longint'(plan_pos[0]);
        hi = longint'(plan_pos[n-1]);
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 11))
            0: return $urandom;
            1, 2: return plan_pos[k];
            3: return plan_pos[k] + 1;
            4: return plan_pos[k] - 1;
            5: return Q_MIN;
            6: return Q_MAX;
            default: begin
                if (hi > lo) begin
                    return pli_pkg::DATA_W'(lo +
                        longint'({$urandom, $urandom} % longint'(hi - lo + 1)));
                end
                return $urandom;
            end
        endcase
    endfunction

    task automatic fill_table(int n, int shape);
        longint p;
        longint stride;
        p = $urandom_range(0, 3) == 0 ? POS_MIN
                                      : longint'(int'($urandom) >>> $urandom_range(1, 8));
        stride = longint'(1) << $urandom_range(4, 30);
        for (int k = 0; k < n; k++) begin
            if (shape == 1) begin
                p = longint'(int'($urandom));
            end else if (shape == 0 && k > 0) begin
                if ($urandom_range(0, 7) != 0) p = p + longint'($urandom) % stride + 1;
                if (p > POS_MAX) p = POS_MAX;
            end
            add_write(k, p[pli_pkg::DATA_W-1:0], pick_value());
        end
    endtask

    task automatic plan_stimulus();
        int idle_rates[4] = '{0, 60, 0, 9};
        int first_points[6] = '{2, 64, 127, 0, 65, 1};
        int phase;
        int pts;
        int n;
        int shape;
        int r;
        add_write(0, 32'sh0001_0000, Q_MIN);
        add_query(Q_MIN);
        add_query(Q_MAX);
        add_query(32'sh0001_0000);
        add_control(ACT_SETUP, 4);
        add_write(0, Q_MIN, Q_MAX);
        add_write(1, -32'sh0001_0000, Q_MIN);
        add_write(2, -32'sh0001_0000, 12345);
        add_write(3, Q_MAX, Q_MAX);
        add_query(Q_MIN);
        add_query(Q_MAX);
        add_query(-32'sh0001_0000);
        add_query(-32'sh0001_0001);
        add_query(32'sh0);
        add_query(32'sh4000_0000);
        add_query(-32'sh4000_0000);
        add_control(ACT_FLUSH, 0);
        add_control(ACT_SETUP, 0);
        add_query(32'sh0);
        add_query(Q_MIN);
        phase = 0;
        while (planned_words < WORD_TARGET) begin
            add_control(ACT_RATE, idle_rates[phase % 4]);
            if (phase < 6) pts = first_points[phase];
            else if ($urandom_range(0, 3) == 0) pts = $urandom_range(0, 127);
            else pts = $urandom_range(1, 8);
            add_control(ACT_SETUP, pts);
            n = used_points(pli_pkg::CFG_W'(pts));
            r = $urandom_range(0, 9);
            shape = r < 8 ? 0 : r - 7;
            fill_table(n, shape);
            if (n < pli_pkg::TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_write($urandom_range(n, pli_pkg::TABLE_DEPTH - 1), $urandom, $urandom);
            end
            repeat ($urandom_range(40, 120)) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    add_write($urandom_range(0, pli_pkg::TABLE_DEPTH - 1), $urandom, $urandom);
                end else if (r == 6) begin
                    add_control(ACT_FLUSH, 0);
                end else begin
                    add_query(pick_query(n));
                end
            end
            phase++;
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            start_nx = start && !word_taken;
            cfg_we_nx = 1'b0;
            if (!busy && !start && expected_y.size() == 0) quiet_cycles++;
            else quiet_cycles = 0;
            if (!start_nx) begin
                while (pending_words.size() > 0 && pending_words[0].act == ACT_RATE) begin
                    head = pending_words.pop_front();
                    idle_pct = int'(head.idle_pct);
                end
                if (pending_words.size() == 0) begin
                    stim_done = 1'b1;
                end else begin
                    head = pending_words[0];
                    case (head.act)
                        ACT_SETUP: begin
                            if (quiet_cycles >= QUIET_CYCLES) begin
                                cfg_we_nx = 1'b1;
                                i_cfg_wdata <= head.points;
                                quiet_cycles = 0;
                                void'(pending_words.pop_front());
                            end
                        end
                        ACT_FLUSH: begin
                            if (quiet_cycles > 0) void'(pending_words.pop_front());
                        end
                        default: begin
                            if ($urandom_range(0, 99) >= idle_pct) begin
                                start_nx = 1'b1;
                                i_cmd <= head.cmd;
                                i_entry_index <= head.idx;
                                i_entry_position <= head.pos;
                                i_entry_value <= head.val;
                                i_query_x <= head.qx;
                                void'(pending_words.pop_front());
                            end
                        end
                    endcase
                end
            end
            start <= start_nx;
            i_cfg_we <= cfg_we_nx;
        end
    end

    always @(posedge i_clk) begin
        logic signed [pli_pkg::DATA_W-1:0] want;
        word_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (i_cfg_we) model_points = i_cfg_wdata;
            if (start && !busy) begin
                if (i_cmd == pli_pkg::CMD_WRITE) begin
                    model_pos[i_entry_index] = i_entry_position;
                    model_val[i_entry_index] = i_entry_value;
                end else begin
                    expected_y.push_back(interpolate_y(i_query_x));
                end
            end
            if (o_result_strobe) begin
                if (expected_y.size() == 0) begin
                    report_mismatch("result_y with no query pending", o_result_y, 'x);
                end else begin
                    want = expected_y.pop_front();
                    if (o_result_y !== want) report_mismatch("result_y", o_result_y, want);
                end
            end
        end
    end

    initial begin
        plan_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!(stim_done && expected_y.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_y.size() != 0) report_mismatch("queries left without result", '0, '0);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
